/* hw/rtl/faded_sine_beep_generator_unit_macros.svh */
// assertion macros for the faded sine beep generator
// used by the top level only; needs i_clk and i_rst_n in scope
`ifndef FADED_SINE_BEEP_GENERATOR_UNIT_MACROS_SVH
`define FADED_SINE_BEEP_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define FSBG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define FSBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fsbg_pkg.sv */
// shared types, constants and the sine table builder for the beep generator
// no dependencies; imported by every module of the block
package fsbg_pkg;

    // table and amplitude
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int AMPLITUDE        = 10000;
    localparam int TBL_IDX_W        = $clog2(SINE_TABLE_DEPTH);
    localparam int TBL_W            = 16;

    // field and state widths
    localparam int SMP_W   = 15;
    localparam int FREQ_W  = 15;
    localparam int MS_W    = 16;
    localparam int RATE_W  = 16;
    localparam int PHASE_W = 32;
    localparam int TOTAL_W = 22;
    localparam int FADE_W  = 9;
    localparam int CAP_W   = 10;
    localparam int CAP_SHIFT = 3;  // fade cap is rate * 8 / 1000

    localparam logic [RATE_W-1:0]  DEFAULT_RATE = RATE_W'(16000);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [FADE_W-1:0]  FADE_MAX     = '1;

    // serial multiplier
    localparam int MUL_W     = 16;
    localparam int MUL_P_W   = 32;
    localparam int MUL_CNT_W = 5;

    // serial divider
    localparam int DIV_DVD_W = 48;
    localparam int DIV_DVS_W = 16;
    localparam int DIV_Q_W   = 32;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_DVS_W-1:0] MS_PER_S = DIV_DVS_W'(1000);

    // fade product: magnitude times ramp numerator
    localparam int FPROD_W = TBL_W - 1 + FADE_W;

    // output saturation bounds
    localparam logic signed [TBL_W:0] SMP_HI = (TBL_W+1)'((1 << (SMP_W-1)) - 1);
    localparam logic signed [TBL_W:0] SMP_LO = -SMP_HI - (TBL_W+1)'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TOT_MUL,
        ST_TOT_DIV,
        ST_CAP_DIV,
        ST_STEP_DIV,
        ST_FADE_MUL,
        ST_FADE_DIV,
        ST_EMIT
    } t_state;

    typedef logic signed [TBL_W-1:0] t_sine_tab [SINE_TABLE_DEPTH];

    localparam logic [63:0] TAB_D       = 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

    // (a*b) >> 62 for q62 values below two
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // restoring long division, one quotient bit per pass
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // rounded amplitude * sin(pi/2 * u / depth), taylor series in q62
    function automatic int quarter_sine(input logic [63:0] u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s40;
        if (u == 64'd0) return 0;
        if (u == TAB_D) return AMPLITUDE;
        if (64'd3 * u == TAB_D) return (AMPLITUDE + 1) / 2;
        x = (PI_HALF_Q62 / TAB_D) * u + ((PI_HALF_Q62 % TAB_D) * u) / TAB_D;
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= 12; n++) begin
            term = udiv64(mul_q62(term, x2), 64'(2 * n) * 64'(2 * n + 1));
            if ((n % 2) == 1) sum = sum - term;
            else sum = sum + term;
        end
        s40 = sum >> 22;
        return int'((s40 * 64'(AMPLITUDE) + (64'd1 << 39)) >> 40);
    endfunction

    // full-wave table from quarter-wave symmetry
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] u;
        int v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            q = (64'd4 * 64'(k)) / TAB_D;
            r = 64'd4 * 64'(k) - q * TAB_D;
            u = q[0] ? TAB_D - r : r;
            v = quarter_sine(u);
            tab[k] = (q >= 64'd2) ? TBL_W'(-v) : TBL_W'(v);
        end
        return tab;
    endfunction

endpackage

/* hw/rtl/fsbg_serial_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on fsbg_pkg
module fsbg_serial_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fsbg_pkg::MUL_W-1:0]     i_mcand,
    input  logic [fsbg_pkg::MUL_W-1:0]     i_mlt,     // left aligned
    input  logic [fsbg_pkg::MUL_CNT_W-1:0] i_steps,
    output fsbg_pkg::t_unit_stat           o_stat,
    output logic [fsbg_pkg::MUL_P_W-1:0]   o_product
);
    import fsbg_pkg::*;

    logic [MUL_P_W-1:0]   r_acc;
    logic [MUL_P_W-1:0]   n_acc;
    logic [MUL_W-1:0]     r_mcand;
    logic [MUL_W-1:0]     r_mlt;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 load;

    assign load = i_start && !r_busy;

    // one shift-add step
    assign n_acc = {r_acc[MUL_P_W-2:0], 1'b0}
                 + (r_mlt[MUL_W-1] ? MUL_P_W'(r_mcand) : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc   <= '0;
            r_mcand <= i_mcand;
            r_mlt   <= i_mlt;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mlt <= {r_mlt[MUL_W-2:0], 1'b0};
        end
    end

    assign o_stat    = '{busy: r_busy, done: r_done};
    assign o_product = r_acc;

endmodule

/* hw/rtl/fsbg_serial_div.sv */
// restoring divider, one quotient bit per cycle, keeps the low quotient bits
// depends on fsbg_pkg
module fsbg_serial_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fsbg_pkg::DIV_DVD_W-1:0] i_dividend,  // left aligned
    input  logic [fsbg_pkg::DIV_CNT_W-1:0] i_steps,
    input  logic [fsbg_pkg::DIV_DVS_W-1:0] i_divisor,
    output fsbg_pkg::t_unit_stat           o_stat,
    output logic [fsbg_pkg::DIV_Q_W-1:0]   o_quotient
);
    import fsbg_pkg::*;

    logic [DIV_DVD_W-1:0] r_dvd;
    logic [DIV_DVS_W-1:0] r_dvs;
    logic [DIV_DVS_W-1:0] r_rem;
    logic [DIV_DVS_W-1:0] n_rem;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W:0]   diff;
    logic                 ge;
    logic                 load;

    assign load = i_start && !r_busy;

    // trial subtract of the shifted partial remainder
    assign trial = {r_rem, r_dvd[DIV_DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_Q_W-2:0], ge};
        end
    end

    assign o_stat     = '{busy: r_busy, done: r_done};
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/faded_sine_beep_generator_unit.sv */
// faded sine beep generator top level: sequencer, tone state, sine rom, output register
// depends on fsbg_pkg, fsbg_serial_mul, fsbg_serial_div and the macros header
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: mode; tdata: freq_hz, beep length in ms
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: sample; tlast: last
// cfg       in   i_cfg_we                     i_cfg_wdata: output rate
//
// a start word runs a 16-step serial multiply, then 32-, 19- and
// 47-step restoring divisions, one bit per cycle in the shared divider
// a tick word uses no unit with no fade and, inside a ramp, a 9-step multiply and a
// 24-step divide; those bit-serial units set the rate, one word in flight at a time
// reset (synchronous, active low) leaves the generator idle with rate 16000
// a finished sample waits in the output register while the next word is taken
`include "faded_sine_beep_generator_unit_macros.svh"

module faded_sine_beep_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fsbg_pkg::RATE_W-1:0]       i_cfg_wdata,    // output rate
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [14:0] freq_hz, [30:15] beep ms
    input  logic                              s_axis_tuser,   // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [14:0] sample
    output logic                              m_axis_tlast    // last
);
    import fsbg_pkg::*;

    localparam t_sine_tab SINE_ROM = build_sine_tab();

    t_state r_state;
    t_state n_state;

    // configuration and tone state
    logic [RATE_W-1:0]    r_out_rate;
    logic                 r_active;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   r_step;
    logic [TOTAL_W-1:0]   r_index;
    logic [TOTAL_W-1:0]   r_total;
    logic [FADE_W-1:0]    r_fade;

    // captured word and work registers
    logic                 r_mode;
    logic [FREQ_W-1:0]    r_freq;
    logic [MS_W-1:0]      r_ms;
    logic [TOTAL_W-1:0]   r_new_total;
    logic [FADE_W-1:0]    r_new_fade;
    logic signed [TBL_W-1:0] r_tbl_q;
    logic [TBL_W-1:0]     r_mag;
    logic                 r_neg;
    logic [FADE_W-1:0]    r_num;
    logic                 r_last;

    // output register
    logic                 r_out_valid;
    logic [SMP_W-1:0]     r_out_sample;
    logic                 r_out_last;

    // unit hookup
    logic                    mul_start;
    logic [MUL_W-1:0]        mul_mcand;
    logic [MUL_W-1:0]        mul_mlt;
    logic [MUL_CNT_W-1:0]    mul_steps;
    t_unit_stat              mul_stat;
    logic [MUL_P_W-1:0]      mul_p;
    logic                    div_start;
    logic [DIV_DVD_W-1:0]    div_dvd;
    logic [DIV_CNT_W-1:0]    div_steps;
    logic [DIV_DVS_W-1:0]    div_dvs;
    t_unit_stat              div_stat;
    logic [DIV_Q_W-1:0]      div_q;

    // combinational helpers
    logic                    in_acc;
    logic                    out_load;
    logic [RATE_W-1:0]       rate_eff;
    logic                    ramp_up;
    logic                    ramp_down;
    logic [TOTAL_W-1:0]      remain;
    logic                    tick_last;
    logic                    do_scale;
    logic [TOTAL_W-1:0]      tot_sat;
    logic [TOTAL_W-1:0]      quarter;
    logic [TOTAL_W-1:0]      cap;
    logic [TOTAL_W-1:0]      fade_min;
    logic signed [TBL_W:0]   s_val;
    logic signed [TBL_W:0]   s_sat;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign rate_eff = (r_out_rate == '0) ? DEFAULT_RATE : r_out_rate;

    // serial units
    fsbg_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_mcand),
        .i_mlt     (mul_mlt),
        .i_steps   (mul_steps),
        .o_stat    (mul_stat),
        .o_product (mul_p)
    );

    fsbg_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_steps    (div_steps),
        .i_divisor  (div_dvs),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    // sine rom, registered read of the top phase bits
    always_ff @(posedge i_clk) begin
        r_tbl_q <= SINE_ROM[r_phase[PHASE_W-1 -: TBL_IDX_W]];
    end

    // ramp position of the current sample
    assign ramp_up   = r_index < TOTAL_W'(r_fade);
    assign ramp_down = ({1'b0, r_index} + (TOTAL_W+1)'(r_fade)) > {1'b0, r_total};
    assign remain    = r_total - r_index;
    assign tick_last = ({1'b0, r_index} + (TOTAL_W+1)'(1)) >= {1'b0, r_total};
    assign do_scale  = (ramp_up || ramp_down) && (r_fade != '0);

    // start arithmetic on divider results
    assign tot_sat  = (div_q[DIV_Q_W-1:TOTAL_W] != '0) ? TOTAL_MAX : div_q[TOTAL_W-1:0];
    assign quarter  = r_new_total >> 2;
    assign cap      = TOTAL_W'(div_q[CAP_W-1:0]);
    assign fade_min = (cap < quarter) ? cap : quarter;

    // signed sample with saturation
    assign s_val = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    always_comb begin
        if (s_val > SMP_HI) s_sat = SMP_HI;
        else if (s_val < SMP_LO) s_sat = SMP_LO;
        else s_sat = s_val;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_mode) begin
                    if (!r_active) n_state = ST_IDLE;
                    else if (do_scale) n_state = ST_FADE_MUL;
                    else n_state = ST_EMIT;
                end else if (r_freq == '0 || r_ms == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_TOT_MUL;
                end
            end
            ST_TOT_MUL: begin
                if (mul_stat.done) n_state = ST_TOT_DIV;
            end
            ST_TOT_DIV: begin
                if (div_stat.done) n_state = (div_q == '0) ? ST_IDLE : ST_CAP_DIV;
            end
            ST_CAP_DIV: begin
                if (div_stat.done) n_state = ST_STEP_DIV;
            end
            ST_STEP_DIV: begin
                if (div_stat.done) n_state = ST_IDLE;
            end
            ST_FADE_MUL: begin
                if (mul_stat.done) n_state = ST_FADE_DIV;
            end
            ST_FADE_DIV: begin
                if (div_stat.done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and unit operands
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        mul_start     = 1'b0;
        mul_mcand     = rate_eff;
        mul_mlt       = r_ms;
        mul_steps     = MUL_CNT_W'(MS_W);
        div_start     = 1'b0;
        div_dvd       = {mul_p, {(DIV_DVD_W-MUL_P_W){1'b0}}};
        div_steps     = DIV_CNT_W'(MUL_P_W);
        div_dvs       = MS_PER_S;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_TOT_MUL: begin
                mul_start = !mul_stat.busy && !mul_stat.done;
            end
            ST_TOT_DIV: begin
                div_start = !div_stat.busy && !div_stat.done;
            end
            ST_CAP_DIV: begin
                div_start = !div_stat.busy && !div_stat.done;
                div_dvd   = {rate_eff, {CAP_SHIFT{1'b0}},
                             {(DIV_DVD_W-RATE_W-CAP_SHIFT){1'b0}}};
                div_steps = DIV_CNT_W'(RATE_W + CAP_SHIFT);
            end
            ST_STEP_DIV: begin
                div_start = !div_stat.busy && !div_stat.done;
                div_dvd   = {r_freq, {PHASE_W{1'b0}}, {(DIV_DVD_W-FREQ_W-PHASE_W){1'b0}}};
                div_steps = DIV_CNT_W'(FREQ_W + PHASE_W);
                div_dvs   = DIV_DVS_W'(rate_eff);
            end
            ST_FADE_MUL: begin
                mul_start = !mul_stat.busy && !mul_stat.done;
                mul_mcand = MUL_W'(r_mag);
                mul_mlt   = {r_num, {(MUL_W-FADE_W){1'b0}}};
                mul_steps = MUL_CNT_W'(FADE_W);
            end
            ST_FADE_DIV: begin
                div_start = !div_stat.busy && !div_stat.done;
                div_dvd   = {mul_p[FPROD_W-1:0], {(DIV_DVD_W-FPROD_W){1'b0}}};
                div_steps = DIV_CNT_W'(FPROD_W);
                div_dvs   = DIV_DVS_W'(r_fade);
            end
            ST_EMIT: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // state, configuration and tone state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_rate    <= DEFAULT_RATE;
            r_active      <= 1'b0;
            r_phase       <= '0;
            r_step        <= '0;
            r_index       <= '0;
            r_total       <= '0;
            r_fade        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_out_rate <= i_cfg_wdata;
            // commit a new tone once the phase step is known
            if (r_state == ST_STEP_DIV && div_stat.done) begin
                r_step   <= div_q;
                r_total  <= r_new_total;
                r_fade   <= r_new_fade;
                r_phase  <= '0;
                r_index  <= '0;
                r_active <= 1'b1;
            end
            // advance after a sample leaves
            if (out_load) begin
                r_phase <= r_phase + r_step;
                r_index <= r_index + TOTAL_W'(1);
                if (r_last) r_active <= 1'b0;
            end
        end
    end

    // captured word and work registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= s_axis_tuser;
            r_freq <= s_axis_tdata[FREQ_W-1:0];
            r_ms   <= s_axis_tdata[FREQ_W +: MS_W];
        end
        if (r_state == ST_TOT_DIV && div_stat.done) r_new_total <= tot_sat;
        if (r_state == ST_CAP_DIV && div_stat.done) begin
            r_new_fade <= (fade_min > TOTAL_W'(FADE_MAX)) ? FADE_MAX : fade_min[FADE_W-1:0];
        end
        // rom data is settled here: the phase last moved before the idle state, so the registered read has caught up
        if (r_state == ST_DECODE) begin
            r_neg  <= r_tbl_q[TBL_W-1];
            r_mag  <= r_tbl_q[TBL_W-1] ? TBL_W'(-r_tbl_q) : TBL_W'(r_tbl_q);
            r_num  <= ramp_up ? r_index[FADE_W-1:0] : remain[FADE_W-1:0];
            r_last <= tick_last;
        end
        if (r_state == ST_FADE_DIV && div_stat.done) r_mag <= div_q[TBL_W-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= s_sat[SMP_W-1:0];
            r_out_last   <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_sample};
    assign m_axis_tlast  = r_out_last;

    // checks
    `FSBG_ASSERT_NOW(a_emit_tick_active, out_load, r_mode && r_active, "sample without an active tick")
    `FSBG_ASSERT_NOW(a_accept_units_idle, in_acc, !mul_stat.busy && !div_stat.busy, "word taken while a unit runs")
    `FSBG_ASSERT_NEXT(a_last_ends_tone, out_load && r_last, !r_active, "tone still active after last sample")
    `FSBG_ASSERT_NOW(a_index_in_range, r_active, r_index < r_total, "sample index beyond tone length")

endmodule

/* sim/testbench.sv */
// self-checking testbench for faded_sine_beep_generator_unit: tone starts, ticks, rate changes
// depends on fsbg_pkg and the generator rtl; predicts every pcm word and compares in order
`timescale 1ns / 1ps

module testbench;
    import fsbg_pkg::*;

    // input word kinds carried on tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int SETTLE_CYCLES  = 200;   // a start runs with no output; this wait lets it finish
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam real HALF_PI       = 1.5707963267948966;

    typedef struct packed {
        logic signed [SMP_W-1:0] pcm;
        logic                    end_flag;
    } t_tone_sample;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RATE_W-1:0]   i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;    // [14:0] freq_hz, [30:15] beep ms
    logic                s_axis_tuser;    // mode
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;    // [14:0] sample
    logic                m_axis_tlast;    // last

    faded_sine_beep_generator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // tone state mirror
    int                  sine_lut [SINE_TABLE_DEPTH];
    logic [RATE_W-1:0]   rate_reg;
    logic                tone_active;
    logic [PHASE_W-1:0]  tone_phase;
    logic [PHASE_W-1:0]  tone_step;
    logic [TOTAL_W-1:0]  tone_index;
    logic [TOTAL_W-1:0]  tone_total;
    logic [FADE_W-1:0]   tone_fade;
    t_tone_sample        pending_samples [$];

    // stimulus pacing and bookkeeping
    int burst_left;
    int gap_max;
    int rx_style;
    int stall_left;
    int rx_count;
    int idle_cycles;
    int mismatches;
    int useful_items;
    int starts_loaded;
    int starts_rejected;
    int idle_ticks;
    int samples_checked;
    int rate_writes;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // table of round(amplitude * sin), built by quarter-wave symmetry
    function automatic void build_sine_lut();
        int  q;
        int  r;
        int  u;
        int  v;
        real a;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            q = (4 * k) / SINE_TABLE_DEPTH;
            r = 4 * k - q * SINE_TABLE_DEPTH;
            u = (q % 2 == 1) ? SINE_TABLE_DEPTH - r : r;
            a = real'(AMPLITUDE) * $sin(HALF_PI * real'(u) / real'(SINE_TABLE_DEPTH));
            v = $rtoi(a + 0.5);
            sine_lut[k] = (q >= 2) ? -v : v;
        end
    endfunction

    // start word: load count, fade and phase step, or leave everything as is
    function automatic void tone_load(input logic [FREQ_W-1:0] freq, input logic [MS_W-1:0] ms);
        logic [63:0] r;
        logic [63:0] total;
        logic [63:0] fade;
        logic [63:0] cap;
        r = (rate_reg == '0) ? 64'(DEFAULT_RATE) : 64'(rate_reg);
        total = r * 64'(ms) / 64'd1000;
        if (freq == '0 || ms == '0 || total == 64'd0) begin
            starts_rejected++;
            return;
        end
        if (total > 64'(TOTAL_MAX)) total = 64'(TOTAL_MAX);
        fade = total / 64'd4;
        cap = r * 64'd8 / 64'd1000;
        if (cap < fade) fade = cap;
        if (fade > 64'(FADE_MAX)) fade = 64'(FADE_MAX);
        tone_total  = TOTAL_W'(total);
        tone_fade   = FADE_W'(fade);
        tone_step   = PHASE_W'((64'(freq) << 32) / r);
        tone_phase  = '0;
        tone_index  = '0;
        tone_active = 1'b1;
        starts_loaded++;
        useful_items++;
    endfunction

    // tick word: one faded sample while a tone runs
    function automatic void tone_next_sample();
        int           s;
        int           mag;
        logic [63:0]  num;
        logic         ramp;
        t_tone_sample want;
        if (!tone_active) begin
            idle_ticks++;
            return;
        end
        s = sine_lut[tone_phase[PHASE_W-1 -: TBL_IDX_W]];
        ramp = 1'b0;
        num = 64'd0;
        if (64'(tone_index) < 64'(tone_fade)) begin
            ramp = 1'b1;
            num = 64'(tone_index);
        end else if (64'(tone_index) + 64'(tone_fade) > 64'(tone_total)) begin
            ramp = 1'b1;
            num = 64'(tone_total - tone_index);
        end
        if (ramp && tone_fade != '0) begin
            mag = (s < 0) ? -s : s;
            mag = int'((64'(mag) * num) / 64'(tone_fade));
            s = (s < 0) ? -mag : mag;
        end
        if (s > 16383) s = 16383;
        if (s < -16384) s = -16384;
        want.pcm = SMP_W'(s);
        want.end_flag = (64'(tone_index) + 64'd1 >= 64'(tone_total));
        pending_samples = {pending_samples, want};
        tone_phase = tone_phase + tone_step;
        tone_index = tone_index + TOTAL_W'(1);
        if (want.end_flag) tone_active = 1'b0;
        useful_items++;
    endfunction

    // send one word in bursts with random gaps, then update the mirror on acceptance
    task automatic send_word(input logic mode, input logic [FREQ_W-1:0] freq,
                             input logic [MS_W-1:0] ms);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, ms, freq};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_START) tone_load(freq, ms);
        else tone_next_sample();
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(MODE_TICK, FREQ_W'($urandom), MS_W'($urandom));
    endtask

    // hold the sender until every expected word is out and any start has finished
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_out_rate(input logic [RATE_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        rate_reg = value;
        rate_writes++;
        i_cfg_we    <= 1'b0;
    endtask

    // idle tick and starts with a zero field
    task automatic test_idle_and_rejects();
        send_ticks(1);
        send_word(MODE_START, 15'd0, 16'd7);
        send_word(MODE_START, 15'd1000, 16'd0);
    endtask

    // fade-in, rejected starts during a tone, and a start that replaces a running tone
    task automatic test_ramp_and_restart();
        send_word(MODE_START, 15'd1000, 16'd1);
        send_ticks(3);
        send_word(MODE_START, 15'd0, 16'hFFFF);
        send_word(MODE_START, 15'd5, 16'd0);
        send_ticks(2);
        send_word(MODE_START, 15'h7FFF, 16'hFFFF);
        send_ticks(2);
    endtask

    // saturated count and fade, zero count, zero fade with very short tones
    task automatic test_rate_extremes();
        settle();
        write_out_rate(16'hFFFF);
        send_word(MODE_START, 15'd24000, 16'hFFFF);
        send_ticks(2);
        settle();
        write_out_rate(16'd1);
        send_word(MODE_START, 15'd1, 16'd999);
        send_word(MODE_START, 15'd7, 16'd1000);
        send_ticks(2);
        settle();
        write_out_rate(16'd3000);
        send_word(MODE_START, 15'd1500, 16'd1);
        send_ticks(4);
    endtask

    // one random segment: mostly complete tones, some noise and cut-off tones
    task automatic play_random_beep();
        int kind;
        int ticks;
        int r_eff;
        int ms_max;
        logic [FREQ_W-1:0] freq;
        r_eff = (rate_reg == '0) ? int'(DEFAULT_RATE) : int'(rate_reg);
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            if ($urandom_range(0, 1) == 0) send_word(MODE_START, '0, MS_W'($urandom));
            else send_word(MODE_START, FREQ_W'($urandom), '0);
            ticks = $urandom_range(0, 3);
        end else if (kind < 14) begin
            ticks = $urandom_range(1, 3);
        end else if (kind < 24) begin
            send_word(MODE_START, FREQ_W'($urandom_range(1, 32767)),
                      MS_W'($urandom_range(1, 65535)));
            ticks = $urandom_range(1, 6);
        end else begin
            ms_max = 120000 / r_eff;
            if (ms_max < 1) ms_max = 1;
            if (ms_max > 65535) ms_max = 65535;
            freq = ($urandom_range(0, 9) < 7) ? FREQ_W'($urandom_range(1, 24000))
                                              : FREQ_W'($urandom_range(1, 32767));
            send_word(MODE_START, freq, MS_W'($urandom_range(1, ms_max)));
            ticks = tone_active ? int'(tone_total - tone_index) : 0;
            if ($urandom_range(0, 6) == 0) ticks = $urandom_range(0, ticks);
            else ticks += $urandom_range(0, 1);
        end
        send_ticks(ticks);
    endtask

    // phases of random tones, each at its own rate and pacing
    task automatic test_random_beeps();
        int goal;
        int quota;
        int phase;
        logic [RATE_W-1:0] rate;
        goal = useful_items + RANDOM_ITEMS;
        phase = 0;
        while (useful_items < goal) begin
            case (phase)
                0: rate = 16'd8000;
                1: rate = 16'd48000;
                2: rate = 16'd0;
                3: rate = 16'hFFFF;
                4: rate = 16'd3000;
                5: rate = 16'd16000;
                default: rate = ($urandom_range(0, 4) == 0) ? RATE_W'($urandom_range(1, 65535))
                                                            : RATE_W'($urandom_range(8000, 48000));
            endcase
            settle();
            write_out_rate(rate);
            gap_max  = (phase == 0) ? 0 : $urandom_range(0, 2) * 6;
            rx_style = (phase == 0) ? 0 : $urandom_range(0, 3);
            quota = useful_items + $urandom_range(120, 200);
            while (useful_items < quota && useful_items < goal) play_random_beep();
            phase++;
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        rx_count <= rx_count + 1;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_style == 1 && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else if (rx_style == 2 && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(3, 30);
        end else if (rx_style == 3) begin
            m_axis_tready <= (rx_count % 5 != 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each output word with the oldest expected sample
    always @(posedge i_clk) begin : check_words
        t_tone_sample            want;
        logic signed [SMP_W-1:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[SMP_W-1:0];
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected word, sample %0d last %0b", $time, got, m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (got !== want.pcm) begin
                    $display("%0t: sample mismatch, expected %0d actual %0d",
                             $time, want.pcm, got);
                    mismatches++;
                end
                if (m_axis_tlast !== want.end_flag) begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.end_flag, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d samples still expected", $time, pending_samples.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_START;
        m_axis_tready <= 1'b1;
        stall_left    = 0;
        rx_count      = 0;
        idle_cycles   = 0;
        rx_style      = 0;
        gap_max       = 0;
        burst_left    = 0;
        mismatches    = 0;
        useful_items  = 0;
        starts_loaded = 0;
        starts_rejected = 0;
        idle_ticks    = 0;
        samples_checked = 0;
        rate_writes   = 0;
        build_sine_lut();
        rate_reg    = DEFAULT_RATE;
        tone_active = 1'b0;
        tone_phase  = '0;
        tone_step   = '0;
        tone_index  = '0;
        tone_total  = '0;
        tone_fade   = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_rejects();
        test_ramp_and_restart();
        test_rate_extremes();
        test_random_beeps();

        // drain, then watch for stray words
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_samples.size() != 0) mismatches++;

        $display("coverage: %0d tones loaded, %0d starts refused, %0d ticks while idle",
                 starts_loaded, starts_rejected, idle_ticks);
        $display("coverage: %0d samples compared across %0d output rate settings",
                 samples_checked, rate_writes);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fsbg_pkg.sv
hw/rtl/fsbg_serial_mul.sv
hw/rtl/fsbg_serial_div.sv
hw/rtl/faded_sine_beep_generator_unit.sv
sim/testbench.sv
